### src/glc_pkg.sv
// Package for the glyph layout block: word types, character codes and color helpers.
// Used by glc_cfg, glc_core and glyph_layout_color_escape; depends on nothing.
package glc_pkg;

    localparam int COLOR_DIGITS = 8;
    localparam int HEX_CNT_W    = 4;
    localparam int DIGIT_IDX_W  = 3;

    localparam logic [15:0] CH_TAB = 16'h0009;
    localparam logic [15:0] CH_LF  = 16'h000A;
    localparam logic [15:0] CH_VT  = 16'h000B;
    localparam logic [15:0] CH_FF  = 16'h000C;
    localparam logic [15:0] CH_CR  = 16'h000D;
    localparam logic [15:0] CH_SP  = 16'h0020;
    localparam logic [15:0] CH_BAR = 16'h007C;
    localparam logic [15:0] CH_C   = 16'h0063;
    localparam logic [15:0] CH_R   = 16'h0072;

    localparam logic [DIGIT_IDX_W-1:0] SLOT_SWAP = 3'd6;

    localparam logic [15:0] LINE_SPACING_RST  = 16'd256;
    localparam logic [31:0] DEFAULT_COLOR_RST = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CFG_LINE_SPACING  = 1'b0,
        CFG_DEFAULT_COLOR = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] line_spacing;
        logic [31:0] default_color;
    } t_cfg;

    typedef struct packed {
        logic               start_of_text;
        logic signed [15:0] extra_advance;
        logic [11:0]        glyph_height;
        logic [11:0]        glyph_width;
        logic [15:0]        char_code;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [19:0]        pos_x;
        logic signed [20:0] pos_y;
        logic signed [16:0] advance;
        logic [31:0]        glyph_color;
    } t_result;

    // Returns the digit in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, 4'(c - 16'h0030)};
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            r = {1'b1, 4'(c - 16'h0057)};
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            r = {1'b1, 4'(c - 16'h0037)};
        end
        return r;
    endfunction

    // Reads the slots in order and stops at the first empty one.
    function automatic logic [31:0] assemble_color(input logic [31:0] nib,
                                                   input logic [7:0]  val);
        logic [31:0] v;
        logic        run;
        v   = '0;
        run = 1'b1;
        for (int p = 0; p < COLOR_DIGITS; p++) begin
            run = run & val[p];
            if (run) begin
                v = {v[27:0], nib[4*p +: 4]};
            end
        end
        return v;
    endfunction

endpackage

### src/glc_cfg.sv
// Configuration registers of the glyph layout block: line spacing and default color.
// Depends on glc_pkg.
module glc_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  glc_pkg::t_cfg_index i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output glc_pkg::t_cfg       o_cfg
);
    import glc_pkg::*;

    logic [15:0] r_line_spacing;
    logic [31:0] r_default_color;

    assign o_cfg_ready = 1'b1;
    assign o_cfg.line_spacing  = r_line_spacing;
    assign o_cfg.default_color = r_default_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_spacing  <= LINE_SPACING_RST;
            r_default_color <= DEFAULT_COLOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINE_SPACING:  r_line_spacing  <= i_cfg_data[15:0];
                CFG_DEFAULT_COLOR: r_default_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### src/glc_core.sv
// Layout state and per-character logic: pen, previous character, color and color code.
// Depends on glc_pkg.
module glc_core #(
    parameter int FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  glc_pkg::t_item   i_item,
    input  glc_pkg::t_cfg    i_cfg,
    output glc_pkg::t_result o_result
);
    import glc_pkg::*;

    localparam int AW = 12 + FRAC_BITS;
    localparam int SW = ((AW > 16) ? AW : 16) + 2;

    logic signed [20:0]     r_pen_x, r_pen_y, n_pen_x, n_pen_y, s_pen_x, s_pen_y;
    logic [15:0]            r_prev, n_prev, s_prev;
    logic [31:0]            r_color, n_color, s_color;
    logic                   r_in_code, n_in_code, s_in_code;
    logic [HEX_CNT_W-1:0]   r_rem, n_rem, s_rem;
    logic [31:0]            r_nib, n_nib, s_nib, nib_upd;
    logic [7:0]             r_val, n_val, s_val, val_upd;

    logic                   is_bar, prev_bar;
    logic [DIGIT_IDX_W-1:0] slot;
    logic [4:0]             dig;
    logic [HEX_CNT_W-1:0]   rem_dec;
    logic [21:0]            y_t, x_t;
    logic [20:0]            px0;
    logic [SW-1:0]          adv_sum;
    logic signed [16:0]     adv;
    logic                   printed;

    always_comb begin
        if (i_item.start_of_text) begin
            s_pen_x   = '0;
            s_pen_y   = '0;
            s_prev    = '0;
            s_color   = i_cfg.default_color;
            s_in_code = 1'b0;
            s_rem     = '0;
            s_nib     = '0;
            s_val     = '0;
        end else begin
            s_pen_x   = r_pen_x;
            s_pen_y   = r_pen_y;
            s_prev    = r_prev;
            s_color   = r_color;
            s_in_code = r_in_code;
            s_rem     = r_rem;
            s_nib     = r_nib;
            s_val     = r_val;
        end
    end

    assign is_bar   = i_item.char_code == CH_BAR;
    assign prev_bar = s_prev == CH_BAR;

    always_comb begin
        slot    = DIGIT_IDX_W'(HEX_CNT_W'(COLOR_DIGITS) - s_rem) ^ SLOT_SWAP;
        dig     = hex_digit(i_item.char_code);
        nib_upd = s_nib;
        val_upd = s_val;
        nib_upd[4*slot +: 4] = dig[3:0];
        val_upd[slot]        = dig[4];
        rem_dec = s_rem - HEX_CNT_W'(1);
    end

    always_comb begin
        y_t = {s_pen_y[20], s_pen_y} - {6'b0, i_cfg.line_spacing};
        px0 = s_pen_x[20] ? '0 : s_pen_x;
        adv_sum = (SW'(i_item.glyph_width) << FRAC_BITS)
                + {{(SW-16){i_item.extra_advance[15]}}, i_item.extra_advance};
        if ((&adv_sum[SW-1:16]) || !(|adv_sum[SW-1:16])) begin
            adv = adv_sum[16:0];
        end else if (adv_sum[SW-1]) begin
            adv = {1'b1, 16'h0000};
        end else begin
            adv = {1'b0, 16'hFFFF};
        end
        x_t = {px0[20], px0} + {{5{adv[16]}}, adv};
        printed = !(i_item.char_code == CH_SP || i_item.char_code == CH_TAB
                    || i_item.char_code == CH_VT || i_item.char_code == CH_FF)
                  || i_item.glyph_width > 12'd1 || i_item.glyph_height > 12'd1;
    end

    always_comb begin
        n_pen_x   = s_pen_x;
        n_pen_y   = s_pen_y;
        n_prev    = i_item.char_code;
        n_color   = s_color;
        n_in_code = s_in_code;
        n_rem     = s_rem;
        n_nib     = s_nib;
        n_val     = s_val;
        o_result.valid       = 1'b0;
        o_result.pos_x       = px0[19:0];
        o_result.pos_y       = s_pen_y;
        o_result.advance     = adv;
        o_result.glyph_color = s_color;
        if (i_item.char_code == CH_CR) begin
            n_prev = i_item.char_code;
        end else if (i_item.char_code == CH_LF) begin
            n_pen_x = '0;
            if (y_t[21] != y_t[20]) begin
                n_pen_y = y_t[21] ? {1'b1, 20'h00000} : {1'b0, 20'hFFFFF};
            end else begin
                n_pen_y = y_t[20:0];
            end
        end else if (is_bar && !prev_bar) begin
            n_prev = i_item.char_code;
        end else if (i_item.char_code == CH_C && prev_bar) begin
            n_in_code = 1'b1;
            n_rem     = HEX_CNT_W'(COLOR_DIGITS);
            n_nib     = '0;
            n_val     = '0;
        end else if (i_item.char_code == CH_R && prev_bar) begin
            n_color = i_cfg.default_color;
        end else if (s_in_code) begin
            n_nib = nib_upd;
            n_val = val_upd;
            n_rem = rem_dec;
            if (rem_dec == '0) begin
                n_in_code = 1'b0;
                n_color   = assemble_color(nib_upd, val_upd);
            end
        end else begin
            o_result.valid = printed;
            if (printed && is_bar) begin
                n_prev = '0;
            end
            if (x_t[21] != x_t[20]) begin
                n_pen_x = x_t[21] ? {1'b1, 20'h00000} : {1'b0, 20'hFFFFF};
            end else begin
                n_pen_x = x_t[20:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_prev    <= '0;
            r_color   <= DEFAULT_COLOR_RST;
            r_in_code <= 1'b0;
            r_rem     <= '0;
            r_nib     <= '0;
            r_val     <= '0;
        end else if (i_step) begin
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
            r_prev    <= n_prev;
            r_color   <= n_color;
            r_in_code <= n_in_code;
            r_rem     <= n_rem;
            r_nib     <= n_nib;
            r_val     <= n_val;
        end
    end

    a_code_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_code |-> (r_rem != '0 && r_rem <= HEX_CNT_W'(COLOR_DIGITS)))
        else $error("color code open with a bad digit count");

    a_pen_y_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pen_y[20] || r_pen_y == '0)
        else $error("pen y went above the first line");

    a_bar_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.valid && is_bar) |=> r_prev == '0)
        else $error("printed bar left previous character set");

    a_result_only_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !s_in_code || (i_item.char_code == CH_C && prev_bar)
                           || (i_item.char_code == CH_R && prev_bar) || !is_bar || prev_bar)
        else $error("result raised inside a color code");

endmodule

### src/glyph_layout_color_escape.sv
// An accepted word passes the input register and the result register before the output.
// Throughput: one word per cycle unless output stalls; pen and color update per word.
// Non-printing words (controls, color codes, blanks at most 1x1) give no output word.
// Reset (i_rst_n low, synchronous) clears the pen, previous character and color code,
// sets the color to all ones, line spacing to 256 and default color to all ones.
// Top level of the glyph layout block: input register, layout core, result register.
module glyph_layout_color_escape #(
    parameter int FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[15:0], glyph_width[27:16], glyph_height[39:28], extra_advance[55:40]
    input  logic [55:0] s_axis_tdata,
    // start_of_text[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pos_x[19:0], pos_y[40:20], advance[57:41], glyph_color[89:58], zero[95:90]
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import glc_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    step;

    glc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (t_cfg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    glc_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (res)
    );

    assign step          = r_in_valid && (!res.valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.glyph_color, r_out.advance, r_out.pos_y, r_out.pos_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.char_code     <= s_axis_tdata[15:0];
            r_item.glyph_width   <= s_axis_tdata[27:16];
            r_item.glyph_height  <= s_axis_tdata[39:28];
            r_item.extra_advance <= s_axis_tdata[55:40];
            r_item.start_of_text <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(step && res.valid))
        else $error("result register overwritten before it was taken");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && res.valid && r_out_valid))
        else $error("input stalled without a waiting result");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.valid) |=> r_out_valid)
        else $error("printed glyph did not reach the output");

endmodule
